// File: rtl/pgr_pkg.sv
`default_nettype none
package pgr_pkg;

    localparam int unsigned PGR_MAX_NODES  = 1024;
    localparam int unsigned PGR_MAX_EDGES  = 4096;
    localparam int unsigned PGR_NODE_W     = 10;
    localparam int unsigned PGR_TOTAL_W    = 11;
    localparam int unsigned PGR_RANK_W     = 32;
    localparam int unsigned PGR_DAMP_W     = 17;
    localparam int unsigned PGR_ITER_W     = 8;
    localparam int unsigned PGR_DIVISOR_W  = 13;

    localparam logic [PGR_DAMP_W-1:0] PGR_DAMP_ONE = 17'd65536;
    localparam logic [PGR_DAMP_W-1:0] PGR_DAMP_RST = 17'd9830;
    localparam logic [PGR_ITER_W-1:0] PGR_ITER_RST = 8'd10;
    localparam logic [PGR_RANK_W-1:0] PGR_RANK_ONE = 32'h4000_0000;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_ADD_EDGE = 2'd1,
        OP_RUN      = 2'd2,
        OP_READ     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2,
        STS_EMPTY = 2'd3
    } t_status;

    typedef enum logic {
        REG_DAMPING    = 1'b0,
        REG_ITER_COUNT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_op                   op;
        logic [PGR_NODE_W-1:0] source_node;
        logic [PGR_NODE_W-1:0] target_node;
    } t_in_word;

    typedef struct packed {
        logic [PGR_RANK_W-1:0]  rank;
        logic [PGR_TOTAL_W-1:0] node_total;
        t_status                status;
    } t_out_word;

    typedef struct packed {
        t_reg_idx              index;
        logic [PGR_DAMP_W-1:0] value;
    } t_cfg_word;

    function automatic logic [PGR_RANK_W-1:0] sat_add(
        input logic [PGR_RANK_W-1:0] a,
        input logic [PGR_RANK_W-1:0] b
    );
        logic [PGR_RANK_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PGR_RANK_W] ? '1 : s[PGR_RANK_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/pgr_ifs.sv
`default_nettype none
interface pgr_in_if import pgr_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pgr_out_if import pgr_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pgr_cfg_if import pgr_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/pagerank_graph_engine_top.sv
// PageRank engine: edges are loaded into an on-chip edge store, a run sets all
// ranks to 1/N and sweeps the nodes in place (Gauss-Seidel) iteration_count
// times; ranks are unsigned Q2.30, damping Q1.16. One command is handled at a
// time and each gives one result word. After reset and after every clear
// command a pass over all MAX_NODES entries zeroes the out-degree memory
// before the next command is taken. In a run every node scans the whole
// edge store, and every term goes through the shared divider.
`default_nettype none
module pagerank_graph_engine_top import pgr_pkg::*; #(
    parameter int unsigned MAX_NODES = PGR_MAX_NODES,
    parameter int unsigned MAX_EDGES = PGR_MAX_EDGES
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    pgr_in_if.sink    i_in,
    pgr_out_if.source o_out,
    pgr_cfg_if.sink   i_cfg
);
    localparam int unsigned NIW = $clog2(MAX_NODES);
    localparam int unsigned EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int unsigned ETW = $clog2(MAX_EDGES + 1);
    localparam int unsigned DVW = (ETW > PGR_TOTAL_W) ? ETW : PGR_TOTAL_W;

    typedef enum logic [13:0] {
        ST_CLR      = 14'b00000000000001,
        ST_IDLE     = 14'b00000000000010,
        ST_DEG      = 14'b00000000000100,
        ST_READ     = 14'b00000000001000,
        ST_DIV_INIT = 14'b00000000010000,
        ST_DIV_TELE = 14'b00000000100000,
        ST_FILL     = 14'b00000001000000,
        ST_NODE     = 14'b00000010000000,
        ST_E_RD     = 14'b00000100000000,
        ST_E_CHK    = 14'b00001000000000,
        ST_E_DEG    = 14'b00010000000000,
        ST_E_DIV    = 14'b00100000000000,
        ST_MUL      = 14'b01000000000000,
        ST_NWR      = 14'b10000000000000
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_out_valid, n_out_valid;
    t_out_word              r_out_word, n_out_word;
    logic [PGR_DAMP_W-1:0]  r_damping;
    logic [PGR_ITER_W-1:0]  r_iter_cnt;
    logic [ETW-1:0]         r_edge_total, n_edge_total;
    logic [PGR_TOTAL_W-1:0] r_node_count, n_node_count;
    logic [NIW-1:0]         r_clr, n_clr;
    logic [PGR_TOTAL_W-1:0] r_node, n_node;
    logic [PGR_ITER_W-1:0]  r_iter, n_iter;
    logic [ETW-1:0]         r_e, n_e;
    logic [PGR_RANK_W-1:0]  r_sum, n_sum;
    logic [PGR_RANK_W-1:0]  r_init, n_init;
    logic [PGR_RANK_W-1:0]  r_tele, n_tele;
    logic [PGR_DAMP_W-1:0]  r_keep, n_keep;
    logic [48:0]            r_prod, n_prod;
    logic [NIW-1:0]         r_src_idx, n_src_idx;

    logic [PGR_NODE_W-1:0]  mem_esrc [MAX_EDGES];
    logic [PGR_NODE_W-1:0]  mem_etgt [MAX_EDGES];
    logic [ETW-1:0]         mem_deg  [MAX_NODES];
    logic [PGR_RANK_W-1:0]  mem_rank [MAX_NODES];
    logic [PGR_NODE_W-1:0]  r_esrc_q, r_etgt_q;
    logic [ETW-1:0]         r_deg_q;
    logic [PGR_RANK_W-1:0]  r_rank_q;

    logic                   w_edge_we;
    logic [EIW-1:0]         w_edge_raddr;
    logic                   w_deg_we;
    logic [NIW-1:0]         w_deg_waddr, w_deg_raddr;
    logic [ETW-1:0]         w_deg_wdata;
    logic                   w_rank_we;
    logic [NIW-1:0]         w_rank_waddr, w_rank_raddr;
    logic [PGR_RANK_W-1:0]  w_rank_wdata;

    logic                   w_div_start, w_div_done;
    logic [PGR_RANK_W-1:0]  w_div_dend, w_div_q;
    logic [DVW-1:0]         w_div_sor;

    logic                   w_in_ready, w_accept;
    t_in_word               w_in;
    logic [PGR_DAMP_W-1:0]  w_dclamp;
    logic [PGR_NODE_W-1:0]  w_hi;
    logic                   w_in_range, w_full, w_last_edge, w_last_node, w_last_iter;

    assign w_in       = i_in.data;
    assign w_in_ready = (r_state == ST_IDLE) && !r_out_valid;
    assign w_accept   = i_in.valid && w_in_ready;
    assign w_dclamp   = (r_damping > PGR_DAMP_ONE) ? PGR_DAMP_ONE : r_damping;
    assign w_hi       = (w_in.source_node > w_in.target_node) ? w_in.source_node
                                                               : w_in.target_node;
    assign w_in_range = (32'(w_in.source_node) < MAX_NODES) &&
                        (32'(w_in.target_node) < MAX_NODES);
    assign w_full      = 32'(r_edge_total) >= MAX_EDGES;
    assign w_last_edge = ETW'(r_e + 1'b1) == r_edge_total;
    assign w_last_node = PGR_TOTAL_W'(r_node + 1'b1) == r_node_count;
    assign w_last_iter = ({1'b0, r_iter} + 1'b1) == {1'b0, r_iter_cnt};

    assign w_edge_raddr = EIW'(r_e);
    assign w_deg_raddr  = (r_state == ST_IDLE) ? NIW'(w_in.source_node) : NIW'(r_esrc_q);
    assign w_rank_raddr = (r_state == ST_IDLE) ? NIW'(w_in.target_node) : NIW'(r_esrc_q);

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;
        n_edge_total = r_edge_total;
        n_node_count = r_node_count;
        n_clr        = r_clr;
        n_node       = r_node;
        n_iter       = r_iter;
        n_e          = r_e;
        n_sum        = r_sum;
        n_init       = r_init;
        n_tele       = r_tele;
        n_keep       = r_keep;
        n_prod       = r_prod;
        n_src_idx    = r_src_idx;
        w_edge_we    = 1'b0;
        w_deg_we     = 1'b0;
        w_deg_waddr  = r_clr;
        w_deg_wdata  = '0;
        w_rank_we    = 1'b0;
        w_rank_waddr = NIW'(r_node);
        w_rank_wdata = r_init;
        w_div_start  = 1'b0;
        w_div_dend   = PGR_RANK_ONE;
        w_div_sor    = DVW'(r_node_count);

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLR: begin
                w_deg_we = 1'b1;
                if (r_clr == NIW'(MAX_NODES - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_out_word  = '{rank: '0, node_total: r_node_count, status: STS_OK};
                    unique case (w_in.op)
                        OP_CLEAR: begin
                            n_edge_total          = '0;
                            n_node_count          = '0;
                            n_clr                 = '0;
                            n_out_word.node_total = '0;
                            n_state               = ST_CLR;
                        end
                        OP_ADD_EDGE: begin
                            if (!w_in_range) begin
                                n_out_word.status = STS_RANGE;
                            end else if (w_full) begin
                                n_out_word.status = STS_FULL;
                            end else begin
                                w_edge_we    = 1'b1;
                                n_edge_total = r_edge_total + 1'b1;
                                if ({1'b0, w_hi} + 1'b1 > r_node_count) begin
                                    n_node_count = {1'b0, w_hi} + 1'b1;
                                end
                                n_out_word.node_total = n_node_count;
                                n_src_idx = NIW'(w_in.source_node);
                                n_state   = ST_DEG;
                            end
                        end
                        OP_RUN: begin
                            if (r_node_count == '0) begin
                                n_out_word.status = STS_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                w_div_start = 1'b1;
                                n_keep      = PGR_DAMP_ONE - w_dclamp;
                                n_state     = ST_DIV_INIT;
                            end
                        end
                        OP_READ: begin
                            if (r_node_count == '0) begin
                                n_out_word.status = STS_EMPTY;
                            end else if ({1'b0, w_in.target_node} >= r_node_count) begin
                                n_out_word.status = STS_RANGE;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DEG: begin
                w_deg_we    = 1'b1;
                w_deg_waddr = r_src_idx;
                w_deg_wdata = r_deg_q + 1'b1;
                n_state     = ST_IDLE;
            end
            ST_READ: begin
                n_out_valid = 1'b1;
                n_out_word  = '{rank: r_rank_q, node_total: r_node_count, status: STS_OK};
                n_state     = ST_IDLE;
            end
            ST_DIV_INIT: begin
                if (w_div_done) begin
                    n_init      = w_div_q;
                    w_div_start = 1'b1;
                    w_div_dend  = PGR_RANK_W'({w_dclamp, 14'b0});
                    n_state     = ST_DIV_TELE;
                end
            end
            ST_DIV_TELE: begin
                if (w_div_done) begin
                    n_tele  = w_div_q;
                    n_node  = '0;
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                w_rank_we = 1'b1;
                if (w_last_node) begin
                    n_node = '0;
                    n_iter = '0;
                    if (r_iter_cnt == '0) begin
                        n_out_valid = 1'b1;
                        n_out_word  = '{rank: '0, node_total: r_node_count, status: STS_OK};
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_NODE;
                    end
                end else begin
                    n_node = r_node + 1'b1;
                end
            end
            ST_NODE: begin
                n_sum   = '0;
                n_e     = '0;
                n_state = (r_edge_total == '0) ? ST_MUL : ST_E_RD;
            end
            ST_E_RD: begin
                n_state = ST_E_CHK;
            end
            ST_E_CHK: begin
                if ({1'b0, r_etgt_q} == r_node) begin
                    n_state = ST_E_DEG;
                end else if (w_last_edge) begin
                    n_state = ST_MUL;
                end else begin
                    n_e     = r_e + 1'b1;
                    n_state = ST_E_RD;
                end
            end
            ST_E_DEG: begin
                if (r_deg_q != '0) begin
                    w_div_start = 1'b1;
                    w_div_dend  = r_rank_q;
                    w_div_sor   = DVW'(r_deg_q);
                    n_state     = ST_E_DIV;
                end else if (w_last_edge) begin
                    n_state = ST_MUL;
                end else begin
                    n_e     = r_e + 1'b1;
                    n_state = ST_E_RD;
                end
            end
            ST_E_DIV: begin
                if (w_div_done) begin
                    n_sum = sat_add(r_sum, w_div_q);
                    if (w_last_edge) begin
                        n_state = ST_MUL;
                    end else begin
                        n_e     = r_e + 1'b1;
                        n_state = ST_E_RD;
                    end
                end
            end
            ST_MUL: begin
                n_prod  = {32'b0, r_keep} * {17'b0, r_sum};
                n_state = ST_NWR;
            end
            ST_NWR: begin
                w_rank_we    = 1'b1;
                w_rank_wdata = sat_add(r_prod[47:16], r_tele);
                n_state      = ST_NODE;
                if (w_last_node) begin
                    n_node = '0;
                    if (w_last_iter) begin
                        n_out_valid = 1'b1;
                        n_out_word  = '{rank: '0, node_total: r_node_count, status: STS_OK};
                        n_state     = ST_IDLE;
                    end else begin
                        n_iter = r_iter + 1'b1;
                    end
                end else begin
                    n_node = r_node + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLR;
            r_out_valid  <= 1'b0;
            r_edge_total <= '0;
            r_node_count <= '0;
            r_clr        <= '0;
            r_damping    <= PGR_DAMP_RST;
            r_iter_cnt   <= PGR_ITER_RST;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_edge_total <= n_edge_total;
            r_node_count <= n_node_count;
            r_clr        <= n_clr;
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    REG_DAMPING:    r_damping  <= i_cfg.data.value;
                    REG_ITER_COUNT: r_iter_cnt <= i_cfg.data.value[PGR_ITER_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_node     <= n_node;
        r_iter     <= n_iter;
        r_e        <= n_e;
        r_sum      <= n_sum;
        r_init     <= n_init;
        r_tele     <= n_tele;
        r_keep     <= n_keep;
        r_prod     <= n_prod;
        r_src_idx  <= n_src_idx;
    end

    always_ff @(posedge i_clk) begin
        if (w_edge_we) begin
            mem_esrc[EIW'(r_edge_total)] <= w_in.source_node;
            mem_etgt[EIW'(r_edge_total)] <= w_in.target_node;
        end
        r_esrc_q <= mem_esrc[w_edge_raddr];
        r_etgt_q <= mem_etgt[w_edge_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_deg_we) begin
            mem_deg[w_deg_waddr] <= w_deg_wdata;
        end
        r_deg_q <= mem_deg[w_deg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_rank_we) begin
            mem_rank[w_rank_waddr] <= w_rank_wdata;
        end
        r_rank_q <= mem_rank[w_rank_raddr];
    end

    pgr_div #(
        .DIVISOR_W (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dend),
        .i_divisor  (w_div_sor),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    a_edge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_edge_total) <= MAX_EDGES)
        else $error("edge count beyond store");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("command taken while busy");

    a_sweep_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_E_CHK || r_state == ST_NWR) |-> (r_node < r_node_count))
        else $error("sweep past last node");

    a_keep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_keep <= PGR_DAMP_ONE))
        else $error("damping weight out of range");

endmodule
`default_nettype wire

// File: rtl/pgr_div.sv
`default_nettype none
module pgr_div import pgr_pkg::*; #(
    parameter int unsigned DIVISOR_W = PGR_DIVISOR_W
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [PGR_RANK_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [PGR_RANK_W-1:0]      o_quotient
);
    localparam int unsigned CNT_W = $clog2(PGR_RANK_W + 1);

    logic [CNT_W-1:0]      r_cnt;
    logic                  r_done;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [PGR_RANK_W-1:0] r_quo;
    logic [DIVISOR_W:0]    w_shift;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;

    // restoring division, one quotient bit per cycle
    assign w_shift = {r_rem, r_quo[PGR_RANK_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(PGR_RANK_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
            r_quo <= {r_quo[PGR_RANK_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire
